>>> rtl/polygon_box_and_area_defines.svh
// assertion macros for the polygon box and area block
// used by the checker; expects clk and rst_n in scope
`ifndef POLYGON_BOX_AND_AREA_DEFINES_SVH
`define POLYGON_BOX_AND_AREA_DEFINES_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pba_pkg.sv
// shared constants and types for the polygon box and area block
// no dependencies
package pba_pkg;

  localparam int COORD_BITS_DEF  = 20;
  localparam int ACC_BITS_DEF    = 58;
  localparam int QUEUE_DEPTH_DEF = 4;

  // per-vertex classification from front to back
  typedef struct packed {
    logic is_first;
    logic is_last;
    logic cnt3;
  } pba_flags_t;

  localparam int FLAG_BITS = $bits(pba_flags_t);

endpackage

>>> rtl/pba_front.sv
// front part: accepts vertices, tracks first/previous vertex, box and count
// depends on pba_pkg
module pba_front #(
  parameter int COORD_BITS = pba_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       q_full,
  input  logic [COORD_BITS-1:0]      in_vertex_x,
  input  logic [COORD_BITS-1:0]      in_vertex_y,
  input  logic                       in_last_vertex,
  output logic                       push,
  output logic [10*COORD_BITS-1:0]   push_coords,
  output pba_pkg::pba_flags_t        push_flags
);

  localparam int CB = COORD_BITS;
  localparam logic [1:0] SEEN_MAX = 2'd3;

  logic [1:0]           seen_r;
  logic signed [CB-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [CB-1:0] lo_x_r, lo_y_r, hi_x_r, hi_y_r;

  logic signed [CB-1:0] cx, cy;
  logic signed [CB-1:0] first_x_nxt, first_y_nxt;
  logic signed [CB-1:0] lo_x_nxt, lo_y_nxt, hi_x_nxt, hi_y_nxt;
  logic [1:0]           seen_nxt;
  logic                 is_first;

  assign cx       = in_vertex_x;
  assign cy       = in_vertex_y;
  assign is_first = (seen_r == 2'd0);
  assign push     = in_valid && !q_full;

  always_comb begin
    first_x_nxt = is_first ? cx : first_x_r;
    first_y_nxt = is_first ? cy : first_y_r;
    if (is_first) begin
      lo_x_nxt = cx;
      hi_x_nxt = cx;
      lo_y_nxt = cy;
      hi_y_nxt = cy;
    end else begin
      lo_x_nxt = (cx < lo_x_r) ? cx : lo_x_r;
      hi_x_nxt = (cx > hi_x_r) ? cx : hi_x_r;
      lo_y_nxt = (cy < lo_y_r) ? cy : lo_y_r;
      hi_y_nxt = (cy > hi_y_r) ? cy : hi_y_r;
    end
    if (in_last_vertex) begin
      seen_nxt = 2'd0;
    end else if (seen_r == SEEN_MAX) begin
      seen_nxt = SEEN_MAX;
    end else begin
      seen_nxt = seen_r + 2'd1;
    end
  end

  assign push_coords = {cx, cy, prev_x_r, prev_y_r, first_x_nxt, first_y_nxt,
                        lo_x_nxt, lo_y_nxt, hi_x_nxt, hi_y_nxt};

  always_comb begin
    push_flags.is_first = is_first;
    push_flags.is_last  = in_last_vertex;
    push_flags.cnt3     = seen_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (push) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev_x_r  <= cx;
      prev_y_r  <= cy;
      first_x_r <= first_x_nxt;
      first_y_r <= first_y_nxt;
      lo_x_r    <= lo_x_nxt;
      lo_y_r    <= lo_y_nxt;
      hi_x_r    <= hi_x_nxt;
      hi_y_r    <= hi_y_nxt;
    end
  end

endmodule

>>> rtl/pba_fifo.sv
// short register queue between front and back
// no dependencies
module pba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/pba_back.sv
// back part: cross products, saturating shoelace sum, area and box result
// depends on pba_pkg
module pba_back #(
  parameter int COORD_BITS = pba_pkg::COORD_BITS_DEF,
  parameter int ACC_BITS   = pba_pkg::ACC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  logic [10*COORD_BITS-1:0]  head_coords,
  input  pba_pkg::pba_flags_t       head_flags,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_BITS-1:0]     out_box_min_x,
  output logic [COORD_BITS-1:0]     out_box_min_y,
  output logic [COORD_BITS-1:0]     out_box_width,
  output logic [COORD_BITS-1:0]     out_box_height,
  output logic [ACC_BITS-2:0]       out_polygon_area,
  output logic                      out_area_overflow
);

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB;
  localparam int TW = PW + 1;
  localparam int SW = ((ACC_BITS > TW) ? ACC_BITS : TW) + 1;

  function automatic logic [ACC_BITS:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                input logic [TW-1:0] t);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    s  = $signed({{(SW-ACC_BITS){a[ACC_BITS-1]}}, a})
       + $signed({{(SW-TW){t[TW-1]}}, t});
    hi = $signed({{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}});
    lo = ~hi;
    if (s > hi) begin
      return {1'b1, hi[ACC_BITS-1:0]};
    end else if (s < lo) begin
      return {1'b1, lo[ACC_BITS-1:0]};
    end else begin
      return {1'b0, s[ACC_BITS-1:0]};
    end
  endfunction

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = head_valid && adv;

  // head unpacking
  logic signed [CB-1:0] hd_x, hd_y, hd_px, hd_py, hd_fx, hd_fy;
  assign hd_x  = head_coords[9*CB +: CB];
  assign hd_y  = head_coords[8*CB +: CB];
  assign hd_px = head_coords[7*CB +: CB];
  assign hd_py = head_coords[6*CB +: CB];
  assign hd_fx = head_coords[5*CB +: CB];
  assign hd_fy = head_coords[4*CB +: CB];

  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  assign p0_nxt = hd_px * hd_y;
  assign p1_nxt = hd_x * hd_py;
  assign p2_nxt = hd_x * hd_fy;
  assign p3_nxt = hd_fx * hd_y;

  // stage 1: products
  logic                s1_valid_r;
  pba_pkg::pba_flags_t s1_flags_r;
  logic [PW-1:0]       p0_r, p1_r, p2_r, p3_r;
  logic [CB-1:0]       s1_lx_r, s1_ly_r, s1_hx_r, s1_hy_r;

  // stage 2: cross terms and box extents
  logic                s2_valid_r;
  pba_pkg::pba_flags_t s2_flags_r;
  logic [TW-1:0]       s2_term_a_r, s2_term_b_r;
  logic [CB-1:0]       s2_lx_r, s2_ly_r, s2_w_r, s2_h_r;

  // stage 3: running sum
  logic                s3_valid_r;
  pba_pkg::pba_flags_t s3_flags_r;
  logic [ACC_BITS-1:0] acc_r;
  logic                sat_r;
  logic [TW-1:0]       s3_term_b_r;
  logic [CB-1:0]       s3_lx_r, s3_ly_r, s3_w_r, s3_h_r;

  // stage 4: closing term
  logic                s4_valid_r;
  logic                s4_cnt3_r;
  logic [ACC_BITS-1:0] s4_acc_r;
  logic                s4_sat_r;
  logic [CB-1:0]       s4_lx_r, s4_ly_r, s4_w_r, s4_h_r;

  logic [ACC_BITS:0]   add_a, add_b;
  logic [ACC_BITS-1:0] mag_nxt;
  logic [ACC_BITS-2:0] area_nxt;

  assign add_a = sat_add(acc_r, s2_term_a_r);
  assign add_b = sat_add(acc_r, s3_term_b_r);

  always_comb begin
    mag_nxt = s4_acc_r[ACC_BITS-1] ? (~s4_acc_r + ACC_BITS'(1)) : s4_acc_r;
    if (!s4_cnt3_r) begin
      area_nxt = '0;
    end else if (mag_nxt[ACC_BITS-1]) begin
      area_nxt = '1;
    end else begin
      area_nxt = mag_nxt[ACC_BITS-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= head_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r && s3_flags_r.is_last;
      out_valid  <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_flags_r <= head_flags;
      p0_r       <= p0_nxt;
      p1_r       <= p1_nxt;
      p2_r       <= p2_nxt;
      p3_r       <= p3_nxt;
      s1_lx_r    <= head_coords[3*CB +: CB];
      s1_ly_r    <= head_coords[2*CB +: CB];
      s1_hx_r    <= head_coords[1*CB +: CB];
      s1_hy_r    <= head_coords[0 +: CB];
    end
    if (adv && s1_valid_r) begin
      s2_flags_r  <= s1_flags_r;
      s2_term_a_r <= {p0_r[PW-1], p0_r} - {p1_r[PW-1], p1_r};
      s2_term_b_r <= {p2_r[PW-1], p2_r} - {p3_r[PW-1], p3_r};
      s2_lx_r     <= s1_lx_r;
      s2_ly_r     <= s1_ly_r;
      s2_w_r      <= s1_hx_r - s1_lx_r;
      s2_h_r      <= s1_hy_r - s1_ly_r;
    end
    if (adv && s2_valid_r) begin
      s3_flags_r  <= s2_flags_r;
      s3_term_b_r <= s2_term_b_r;
      s3_lx_r     <= s2_lx_r;
      s3_ly_r     <= s2_ly_r;
      s3_w_r      <= s2_w_r;
      s3_h_r      <= s2_h_r;
      if (s2_flags_r.is_first) begin
        acc_r <= '0;
        sat_r <= 1'b0;
      end else begin
        acc_r <= add_a[ACC_BITS-1:0];
        sat_r <= sat_r | add_a[ACC_BITS];
      end
    end
    if (adv && s3_valid_r && s3_flags_r.is_last) begin
      s4_cnt3_r <= s3_flags_r.cnt3;
      s4_acc_r  <= add_b[ACC_BITS-1:0];
      s4_sat_r  <= sat_r | add_b[ACC_BITS];
      s4_lx_r   <= s3_lx_r;
      s4_ly_r   <= s3_ly_r;
      s4_w_r    <= s3_w_r;
      s4_h_r    <= s3_h_r;
    end
    if (adv && s4_valid_r) begin
      out_box_min_x     <= s4_lx_r;
      out_box_min_y     <= s4_ly_r;
      out_box_width     <= s4_w_r;
      out_box_height    <= s4_h_r;
      out_polygon_area  <= area_nxt;
      out_area_overflow <= s4_sat_r;
    end
  end

endmodule

>>> rtl/polygon_box_and_area.sv
// top level of the polygon box and area block
// depends on pba_pkg, pba_front, pba_fifo, pba_back
//
// Takes one polygon vertex per cycle while in_stall is low and, on the vertex
// flagged last, returns the bounding box and twice the shoelace area of the
// polygon. A result word passes from the queue through the product, cross-term,
// running-sum and closing-term stages to the output register. That intake rate
// is held by the four product multipliers, registered after the queue, and by
// the saturating add of the running sum. A queue of QUEUE_DEPTH words sits
// between vertex intake and the arithmetic pipeline.
module polygon_box_and_area #(
  parameter int COORD_BITS  = pba_pkg::COORD_BITS_DEF,
  parameter int ACC_BITS    = pba_pkg::ACC_BITS_DEF,
  parameter int QUEUE_DEPTH = pba_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_vertex_x,
  input  logic [COORD_BITS-1:0] in_vertex_y,
  input  logic                  in_last_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_box_min_x,
  output logic [COORD_BITS-1:0] out_box_min_y,
  output logic [COORD_BITS-1:0] out_box_width,
  output logic [COORD_BITS-1:0] out_box_height,
  output logic [ACC_BITS-2:0]   out_polygon_area,
  output logic                  out_area_overflow
);

  localparam int CRD_W = 10 * COORD_BITS;
  localparam int ENT_W = CRD_W + pba_pkg::FLAG_BITS;

  logic                push, pop, q_full, q_not_empty;
  logic [CRD_W-1:0]    push_coords;
  pba_pkg::pba_flags_t push_flags, head_flags;
  logic [ENT_W-1:0]    head_data;

  assign in_stall   = q_full;
  assign head_flags = pba_pkg::pba_flags_t'(head_data[ENT_W-1:CRD_W]);

  pba_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .q_full         (q_full),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .push           (push),
    .push_coords    (push_coords),
    .push_flags     (push_flags)
  );

  pba_fifo #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_coords}),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (head_data)
  );

  pba_back #(.COORD_BITS(COORD_BITS), .ACC_BITS(ACC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_not_empty),
    .head_coords       (head_data[CRD_W-1:0]),
    .head_flags        (head_flags),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_box_min_x     (out_box_min_x),
    .out_box_min_y     (out_box_min_y),
    .out_box_width     (out_box_width),
    .out_box_height    (out_box_height),
    .out_polygon_area  (out_polygon_area),
    .out_area_overflow (out_area_overflow)
  );

endmodule

>>> rtl/pba_checker.sv
// port-level checker for the polygon box and area block, bound to the top
// depends on pba_pkg, polygon_box_and_area_defines.svh and polygon_box_and_area
`include "polygon_box_and_area_defines.svh"

module pba_checker #(
  parameter int COORD_BITS = pba_pkg::COORD_BITS_DEF,
  parameter int ACC_BITS   = pba_pkg::ACC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_last_vertex,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_box_min_x,
  input logic [COORD_BITS-1:0] out_box_min_y,
  input logic [COORD_BITS-1:0] out_box_width,
  input logic [COORD_BITS-1:0] out_box_height,
  input logic [ACC_BITS-2:0]   out_polygon_area,
  input logic                  out_area_overflow
);

  localparam int CB = COORD_BITS;
  localparam int PEND_BITS = 5;
  localparam logic [CB+1:0] COORD_MAX = {3'b000, {(CB-1){1'b1}}};

  logic [PEND_BITS-1:0] pend_r, pend_nxt;
  logic [CB+1:0]        top_x, top_y;
  logic                 in_acc_last, out_acc;

  assign in_acc_last = in_valid && !in_stall && in_last_vertex;
  assign out_acc     = out_valid && !out_stall;

  // words promised by a last vertex and not yet taken
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc_last && !out_acc) begin
      pend_nxt = pend_r + PEND_BITS'(1);
    end else if (out_acc && !in_acc_last) begin
      pend_nxt = pend_r - PEND_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  assign top_x = {{2{out_box_min_x[CB-1]}}, out_box_min_x} + {2'b00, out_box_width};
  assign top_y = {{2{out_box_min_y[CB-1]}}, out_box_min_y} + {2'b00, out_box_height};

  `PBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_polygon_area) && $stable(out_area_overflow) && $stable(out_box_min_x) && $stable(out_box_width), "stalled result word changed")
  `PBA_ASSERT_NOW(a_box_x_fits, out_valid, $signed(top_x) <= $signed(COORD_MAX), "box right edge out of coordinate range")
  `PBA_ASSERT_NOW(a_box_y_fits, out_valid, $signed(top_y) <= $signed(COORD_MAX), "box top edge out of coordinate range")
  `PBA_ASSERT_NOW(a_out_has_cause, out_valid, pend_r != '0, "result word without a last vertex")

endmodule

bind polygon_box_and_area pba_checker #(
  .COORD_BITS (COORD_BITS),
  .ACC_BITS   (ACC_BITS)
) u_pba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_vertex    (in_last_vertex),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_box_min_x     (out_box_min_x),
  .out_box_min_y     (out_box_min_y),
  .out_box_width     (out_box_width),
  .out_box_height    (out_box_height),
  .out_polygon_area  (out_polygon_area),
  .out_area_overflow (out_area_overflow)
);
